@@ src/tph_pkg.sv @@
// Shared types and constants for the decimal/hex token parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tph_pkg;

  localparam int CH_W  = 8;
  localparam int NUM_W = 32;
  localparam int ST_W  = 2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

  // Character codes.
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;

  // One result item as it sits in the output queue.
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [ST_W-1:0]  status;
    logic             last;
  } res_t;

endpackage

@@ src/tph_if.sv @@
// Valid/ready channel interfaces for the token parser: characters in, results out.
// Depends on tph_pkg for the payload widths.
`timescale 1ns / 1ps

interface tph_ch_if;
  import tph_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface tph_res_if;
  import tph_pkg::*;

  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;
  logic [ST_W-1:0]  status;
  logic             last;

  modport source (output valid, output number, output status, output last, input ready);
  modport sink   (input valid, input number, input status, input last, output ready);
endinterface

@@ src/decimal_hex_token_parser.sv @@
// Top level of the streaming decimal/hexadecimal token parser.
// Depends on tph_pkg and on the channel interfaces in tph_if.sv.
`timescale 1ns / 1ps

//  Channel | Direction | Payload               | Transaction
//  --------+-----------+-----------------------+---------------------------------------
//  ch_i    | in        | ch[7:0]               | one character of the command string
//  res_o   | out       | number, status, last   | one parsed token or status report
//
// Each accepted character is decoded in the cycle it arrives: the parser state
// (mode, accumulator, overflow and whitespace flags) and up to two results are
// updated at that same clock edge, so one character can be taken every cycle
// while ch_i.ready is high. Results go to a four-entry output queue and leave at
// one per cycle while res_o.ready is high; a character that yields two results
// therefore costs two output transfers. ch_i.ready is high while the queue has
// room for two results; it does not depend on res_o.ready in the same cycle.
// Reset empties the queue and puts the parser at the start of a string.

module decimal_hex_token_parser #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tph_ch_if.sink           ch_i,
  tph_res_if.source        res_o
);
  import tph_pkg::*;

  // Parser modes.
  localparam logic [2:0] M_IDLE      = 3'd0;
  localparam logic [2:0] M_DEC       = 3'd1;
  localparam logic [2:0] M_ZERO      = 3'd2;
  localparam logic [2:0] M_HEXPREFIX = 3'd3;
  localparam logic [2:0] M_HEX       = 3'd4;
  localparam logic [2:0] M_SKIP      = 3'd5;

  localparam int WW     = VALUE_WIDTH + 4;
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // Parser state.
  logic [2:0]             mode_q, mode_d;
  logic [VALUE_WIDTH-1:0] accum_q, accum_d;
  logic                   ovf_q, ovf_d;
  logic                   aw_q, aw_d;

  // Output queue.
  res_t                   queue_q [QDEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   ch_acc, res_acc;

  // Character classification.
  logic [CH_W-1:0]        c;
  logic                   is_ws, is_digit, is_letter, is_x, is_hexd, is_af;
  logic [3:0]             hv;

  // Digit accumulation: both candidate products are formed with shifts and adds.
  logic [WW-1:0]          acc_w, prod10, prod16;
  logic                   ovf10, ovf16;

  // Results caused by this character.
  logic                   r0_v, r1_v;
  res_t                   r0, r1;
  res_t                   fin;
  logic                   fin_v;

  assign c         = ch_i.ch;
  assign is_ws     = (c == CH_SPACE) || (c == CH_TAB);
  assign is_digit  = c inside {[CH_0:CH_9]};
  assign is_letter = c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};
  assign is_x      = (c == CH_LX) || (c == CH_UX);
  assign is_af     = c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]};
  assign is_hexd   = is_digit || is_af;
  // For a..f and A..F the low nibble is 1..6, so adding 9 gives 10..15.
  assign hv        = is_digit ? c[3:0] : (is_af ? c[3:0] + 4'd9 : 4'd0);

  assign acc_w  = WW'(accum_q);
  assign prod10 = (acc_w << 3) + (acc_w << 1) + WW'(hv);
  assign prod16 = (acc_w << 4) + WW'(hv);
  assign ovf10  = |prod10[WW-1:VALUE_WIDTH];
  assign ovf16  = |prod16[WW-1:VALUE_WIDTH];

  // The report a pending token gives when it ends.
  always_comb begin
    fin   = '0;
    fin_v = 1'b0;
    if (mode_q == M_DEC || mode_q == M_ZERO || mode_q == M_HEX) begin
      fin_v      = 1'b1;
      fin.number = NUM_W'(accum_q);
      fin.status = ovf_q ? ST_OVERFLOW : ST_OK;
    end else if (mode_q == M_HEXPREFIX || mode_q == M_SKIP) begin
      fin_v      = 1'b1;
      fin.status = ST_INVALID;
    end
  end

  always_comb begin
    res_t inv;
    res_t emp;

    inv        = '0;
    inv.status = ST_INVALID;
    emp        = '0;
    emp.status = ST_EMPTY;

    mode_d  = mode_q;
    accum_d = accum_q;
    ovf_d   = ovf_q;
    aw_d    = aw_q;
    r0_v    = 1'b0;
    r1_v    = 1'b0;
    r0      = '0;
    r1      = '0;

    if (c == CH_NUL) begin
      // End of string: pending token or invalid after whitespace, empty, restart.
      if (mode_q != M_IDLE) begin
        r0_v = 1'b1;
        r0   = fin;
        r1_v = 1'b1;
        r1   = emp;
      end else if (aw_q) begin
        r0_v = 1'b1;
        r0   = inv;
        r1_v = 1'b1;
        r1   = emp;
      end else begin
        r0_v = 1'b1;
        r0   = emp;
      end
      mode_d  = M_IDLE;
      accum_d = '0;
      ovf_d   = 1'b0;
      aw_d    = 1'b0;
    end else if (is_ws) begin
      if (mode_q != M_IDLE) begin
        r0_v = fin_v;
        r0   = fin;
      end
      mode_d  = M_IDLE;
      accum_d = '0;
      ovf_d   = 1'b0;
      aw_d    = 1'b1;
    end else begin
      aw_d = 1'b0;
      case (mode_q)
        M_IDLE: begin
          if (is_digit) begin
            mode_d  = (c == CH_0) ? M_ZERO : M_DEC;
            accum_d = VALUE_WIDTH'(hv);
            ovf_d   = 1'b0;
          end else if (is_letter) begin
            mode_d = M_SKIP;
          end else begin
            r0_v = 1'b1;
            r0   = inv;
          end
        end
        M_ZERO, M_DEC, M_HEX: begin
          if (mode_q == M_ZERO && is_x) begin
            mode_d = M_HEXPREFIX;
          end else if (mode_q != M_HEX && is_digit) begin
            mode_d = M_DEC;
            if (!ovf_q) begin
              accum_d = ovf10 ? '1 : prod10[VALUE_WIDTH-1:0];
              ovf_d   = ovf10;
            end
          end else if (mode_q == M_HEX && is_hexd) begin
            if (!ovf_q) begin
              accum_d = ovf16 ? '1 : prod16[VALUE_WIDTH-1:0];
              ovf_d   = ovf16;
            end
          end else if (mode_q == M_DEC && is_x) begin
            // An x after decimal digits spoils the whole token.
            mode_d  = M_SKIP;
            accum_d = '0;
            ovf_d   = 1'b0;
          end else if (is_letter) begin
            // The value is reported and the letter starts an error token.
            r0_v    = 1'b1;
            r0      = fin;
            mode_d  = M_SKIP;
            accum_d = '0;
            ovf_d   = 1'b0;
          end else begin
            // A stray symbol ends the number and is itself reported invalid.
            r0_v    = 1'b1;
            r0      = fin;
            r1_v    = 1'b1;
            r1      = inv;
            mode_d  = M_IDLE;
            accum_d = '0;
            ovf_d   = 1'b0;
          end
        end
        M_HEXPREFIX: begin
          if (is_hexd) begin
            mode_d = M_HEX;
            if (!ovf_q) begin
              accum_d = ovf16 ? '1 : prod16[VALUE_WIDTH-1:0];
              ovf_d   = ovf16;
            end
          end else begin
            mode_d = M_SKIP;
          end
        end
        default: begin
          mode_d = M_SKIP;
        end
      endcase
    end

    // Flag the final result of this character.
    if (r1_v) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  // Room for two results keeps the queue from ever overflowing.
  assign ch_i.ready = (cnt_q <= CNT_W'(QDEPTH - 2));
  assign ch_acc     = ch_i.valid && ch_i.ready;

  assign res_o.valid  = (cnt_q != '0);
  assign res_o.number = queue_q[rd_ptr_q].number;
  assign res_o.status = queue_q[rd_ptr_q].status;
  assign res_o.last   = queue_q[rd_ptr_q].last;
  assign res_acc      = res_o.valid && res_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (ch_acc) begin
      cnt_d = cnt_d + CNT_W'(r0_v) + CNT_W'(r1_v);
    end
    if (res_acc) begin
      cnt_d = cnt_d - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      accum_q  <= '0;
      ovf_q    <= 1'b0;
      aw_q     <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (ch_acc) begin
        mode_q   <= mode_d;
        accum_q  <= accum_d;
        ovf_q    <= ovf_d;
        aw_q     <= aw_d;
        wr_ptr_q <= wr_ptr_q + PTR_W'(r0_v) + PTR_W'(r1_v);
      end
      if (res_acc) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue payload needs no reset; the count says which entries hold data.
  always_ff @(posedge clk_i) begin
    if (ch_acc && r0_v) begin
      queue_q[wr_ptr_q] <= r0;
    end
    if (ch_acc && r1_v) begin
      queue_q[wr_ptr_q + PTR_W'(1)] <= r1;
    end
  end

  // The queue never holds more results than it has entries.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QDEPTH))
    else $error("output queue count exceeds its depth");

  // An idle parser holds no partial value.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_IDLE |-> (accum_q == '0 && !ovf_q))
    else $error("idle parser holds a stale accumulator");

  // The end of the string returns the parser to its reset state.
  a_eos_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_acc && ch_i.ch == CH_NUL) |=> (mode_q == M_IDLE && !aw_q))
    else $error("parser not back at string start after end of string");

  // A second result is only produced together with a first one.
  a_res_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_acc && r1_v) |-> r0_v)
    else $error("second result without a first");

endmodule

@@ dv/decimal_hex_token_parser_test.sv @@
// Self-checking testbench for decimal_hex_token_parser: directed and random strings in, tokens out.
// Depends on tph_pkg, the channel interfaces in tph_if.sv and the parser RTL.
`timescale 1ns / 1ps

module decimal_hex_token_parser_test;
  import tph_pkg::*;

  localparam int VALUE_WIDTH  = 32;
  localparam int MAX_GAP      = 18;   // longest random wait on either side
  localparam int HOLD_CYCLES  = 200;  // long receiver hold-off that fills the output queue
  localparam int DRAIN_CYCLES = 20;   // settle time after the last expected result
  localparam int RANDOM_CHARS = 750;

  // Parser modes tracked by the predictor.
  typedef enum logic [2:0] {
    PM_IDLE,
    PM_DEC,
    PM_ZERO,
    PM_HEXPREFIX,
    PM_HEX,
    PM_SKIP
  } parse_mode_e;

  // Token scoreboard: tracks the parser state character by character, keeps the results
  // each accepted character must produce, and checks the results the block returns.
  class token_scoreboard;
    parse_mode_e mode;
    logic [63:0] accum;
    bit          ovf;
    bit          after_ws;
    logic [63:0] value_max;
    res_t        token_q[$];
    int          mismatches;

    function new(int vw);
      value_max  = (vw >= 64) ? '1 : ((64'd1 << vw) - 64'd1);
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode     = PM_IDLE;
      accum    = '0;
      ovf      = 1'b0;
      after_ws = 1'b0;
    endfunction

    function void push_result(logic [63:0] num, logic [ST_W-1:0] st);
      res_t r;
      r.number = num[NUM_W-1:0];
      r.status = st;
      r.last   = 1'b0;
      token_q.push_back(r);
    endfunction

    function void add_digit(logic [63:0] base, logic [63:0] d);
      if (ovf) return;
      if (d > value_max || accum > (value_max - d) / base) begin
        accum = value_max;
        ovf   = 1'b1;
      end else begin
        accum = accum * base + d;
      end
    endfunction

    function void close_token();
      case (mode)
        PM_DEC, PM_ZERO, PM_HEX: push_result(accum, ovf ? ST_OVERFLOW : ST_OK);
        PM_HEXPREFIX, PM_SKIP:   push_result('0, ST_INVALID);
        default: ;
      endcase
      mode  = PM_IDLE;
      accum = '0;
      ovf   = 1'b0;
    endfunction

    // Called once per accepted character transaction.
    function void note_char(logic [CH_W-1:0] c);
      int          first;
      bit          ws;
      bit          digit;
      bit          letter;
      bit          is_x;
      bit          hexd;
      logic [63:0] hv;
      first  = token_q.size();
      ws     = (c == CH_SPACE) || (c == CH_TAB);
      digit  = (c >= CH_0) && (c <= CH_9);
      letter = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
      is_x   = (c == CH_LX) || (c == CH_UX);
      hexd   = digit || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
      hv     = '0;
      if (digit) hv = 64'(c - CH_0);
      else if ((c >= CH_LA) && (c <= CH_LF)) hv = 64'(c - CH_LA + 8'd10);
      else if ((c >= CH_UA) && (c <= CH_UF)) hv = 64'(c - CH_UA + 8'd10);

      if (c == CH_NUL) begin
        if (mode != PM_IDLE) close_token();
        else if (after_ws) push_result('0, ST_INVALID);
        push_result('0, ST_EMPTY);
        clear_state();
      end else if (ws) begin
        if (mode != PM_IDLE) close_token();
        after_ws = 1'b1;
      end else begin
        case (mode)
          PM_IDLE: begin
            if (digit) begin
              mode  = (c == CH_0) ? PM_ZERO : PM_DEC;
              accum = hv;
              ovf   = 1'b0;
            end else if (letter) begin
              mode = PM_SKIP;
            end else begin
              push_result('0, ST_INVALID);
            end
          end
          PM_ZERO: begin
            if (is_x) begin
              mode = PM_HEXPREFIX;
            end else if (digit) begin
              mode = PM_DEC;
              add_digit(64'd10, hv);
            end else if (letter) begin
              close_token();
              mode = PM_SKIP;
            end else begin
              close_token();
              push_result('0, ST_INVALID);
            end
          end
          PM_DEC: begin
            if (digit) begin
              add_digit(64'd10, hv);
            end else if (is_x) begin
              mode  = PM_SKIP;
              accum = '0;
              ovf   = 1'b0;
            end else if (letter) begin
              close_token();
              mode = PM_SKIP;
            end else begin
              close_token();
              push_result('0, ST_INVALID);
            end
          end
          PM_HEXPREFIX: begin
            if (hexd) begin
              mode = PM_HEX;
              add_digit(64'd16, hv);
            end else begin
              mode = PM_SKIP;
            end
          end
          PM_HEX: begin
            if (hexd) begin
              add_digit(64'd16, hv);
            end else if (letter) begin
              close_token();
              mode = PM_SKIP;
            end else begin
              close_token();
              push_result('0, ST_INVALID);
            end
          end
          default: mode = PM_SKIP;
        endcase
        after_ws = 1'b0;
      end

      if (token_q.size() > first) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    // Called once per accepted result transaction.
    function void check_result(logic [NUM_W-1:0] number, logic [ST_W-1:0] status, logic last);
      res_t want;
      if (token_q.size() == 0) begin
        report($sformatf("unexpected result number=%h status=%0d last=%0d",
                         number, status, last));
        return;
      end
      want = token_q.pop_front();
      if (want.number !== number || want.status !== status || want.last !== last)
        report($sformatf({"result mismatch: expected number=%h status=%0d last=%0d, ",
                          "got number=%h status=%0d last=%0d"},
                         want.number, want.status, want.last, number, status, last));
    endfunction

    function int outstanding();
      return token_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tph_ch_if  ch_bus ();
  tph_res_if res_bus ();

  decimal_hex_token_parser #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ch_i  (ch_bus),
    .res_o (res_bus)
  );

  token_scoreboard sb = new(VALUE_WIDTH);

  // Idle limits for both sides; the stimulus process changes them from line to line so
  // that some stretches run back to back and others are full of gaps.
  int src_gap_max = 0;
  int snk_gap_max = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request = 1'b0;
  int chars_sent = 0;

  // Characters of the command string being assembled.
  logic [CH_W-1:0] line_buf[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Overall watchdog. The slowest legal run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("decimal_hex_token_parser regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Character generation. The push and build helpers append to line_buf.
  // ---------------------------------------------------------------------------

  function automatic bit is_symbol(logic [CH_W-1:0] c);
    bit letter;
    letter = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    return !(letter || ((c >= CH_0) && (c <= CH_9)) || c == CH_SPACE || c == CH_TAB ||
             c == CH_NUL);
  endfunction

  function automatic logic [CH_W-1:0] rand_letter();
    int v;
    v = $urandom_range(0, 51);
    return (v < 26) ? CH_W'(CH_LA + v) : CH_W'(CH_UA + (v - 26));
  endfunction

  // Any byte that is not a letter, digit, whitespace or end of string, the high half included.
  function automatic logic [CH_W-1:0] rand_symbol();
    logic [CH_W-1:0] c;
    do c = CH_W'($urandom_range(1, 255)); while (!is_symbol(c));
    return c;
  endfunction

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void push_whitespace();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void push_leading_zeros();
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) line_buf.push_back(CH_0);
  endfunction

  // Decimal values lean toward the 32-bit boundary so that saturation shows up often.
  function automatic void push_decimal();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 9));
      1: v = 64'($urandom_range(0, 99999));
      2: v = 64'($urandom);
      3: v = 64'hFFFF_FFFF;
      4: v = 64'h1_0000_0000 + 64'($urandom_range(0, 3));
      default: v = {$urandom, $urandom};
    endcase
    push_leading_zeros();
    push_text($sformatf("%0d", v));
  endfunction

  function automatic void push_hex();
    logic [63:0] v;
    string       s;
    int          i;
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 15));
      1: v = 64'($urandom_range(0, 65535));
      2: v = 64'($urandom);
      3: v = 64'hFFFF_FFFF;
      4: v = 64'h1_0000_0000 + 64'($urandom_range(0, 15));
      default: v = {$urandom, $urandom};
    endcase
    s = $sformatf("%0h", v);
    for (i = 0; i < s.len(); i++)
      if (s[i] >= CH_LA && s[i] <= CH_LF && $urandom_range(0, 1)) s[i] = s[i] - 8'd32;
    line_buf.push_back(CH_0);
    line_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    push_leading_zeros();
    push_text(s);
  endfunction

  function automatic void push_token();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      push_decimal();
    end else if (kind < 50) begin
      push_hex();
    end else if (kind < 55) begin
      line_buf.push_back(CH_0);
    end else if (kind < 65) begin
      // Token that starts with a letter; its tail may hold anything but whitespace or end of string.
      line_buf.push_back(rand_letter());
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 2))
          0: line_buf.push_back(rand_letter());
          1: line_buf.push_back(CH_W'(CH_0 + $urandom_range(0, 9)));
          default: line_buf.push_back(rand_symbol());
        endcase
      end
    end else if (kind < 72) begin
      // Decimal digits followed by an x, as in 10x12 or 00x12.
      if ($urandom_range(0, 1)) line_buf.push_back(CH_0);
      push_text($sformatf("%0d", $urandom_range(0, 99)));
      line_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      push_text($sformatf("%0d", $urandom_range(0, 999)));
    end else if (kind < 78) begin
      // Hex prefix with no usable digit after it.
      line_buf.push_back(CH_0);
      line_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      case ($urandom_range(0, 2))
        0: ;
        1: line_buf.push_back(CH_W'(CH_LA + $urandom_range(6, 25)));
        default: line_buf.push_back(rand_symbol());
      endcase
    end else if (kind < 92) begin
      line_buf.push_back(rand_symbol());
    end else begin
      line_buf.push_back(CH_W'($urandom_range(1, 255)));
    end
  endfunction

  // One well-formed command string: tokens with mostly whitespace between them, sometimes
  // glued together or split by a symbol, closed by the end-of-string byte.
  function automatic void build_line();
    int ntok;
    int k;
    if ($urandom_range(0, 2) == 0) push_whitespace();
    ntok = $urandom_range(1, 6);
    for (k = 0; k < ntok; k++) begin
      push_token();
      if (k == ntok - 1 && $urandom_range(0, 1)) break;
      case ($urandom_range(0, 9))
        7: ;
        8: line_buf.push_back(rand_symbol());
        9: begin
          line_buf.push_back(rand_symbol());
          push_whitespace();
        end
        default: push_whitespace();
      endcase
    end
    line_buf.push_back(CH_NUL);
  endfunction

  // Raw noise; a zero byte may land anywhere in it.
  function automatic void build_noise();
    repeat ($urandom_range(1, 10)) line_buf.push_back(CH_W'($urandom_range(0, 255)));
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return MAX_GAP;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offers one character and waits for its transaction. valid stays high between back-to-back
  // characters; it is only lowered when a gap is drawn, so it never gets two updates in one step.
  task automatic send_char(logic [CH_W-1:0] c);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      ch_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ch_bus.valid <= 1'b1;
    ch_bus.ch    <= c;
    do @(posedge clk_i); while (!ch_bus.ready);
    sb.note_char(c);
    chars_sent++;
  endtask

  task automatic send_line();
    while (line_buf.size() > 0) send_char(line_buf.pop_front());
  endtask

  // Stops offering characters and waits for every outstanding result. The check only follows a
  // rising edge, so that the lowered valid never shares a step with the next raise.
  task automatic wait_for_results();
    ch_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side. Values are read right after the rising edge, before the block's own
  // registers move, so each check sees exactly what was presented at the transaction.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    res_bus.ready = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = $urandom_range(0, snk_gap_max);
      end
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
      sb.check_result(res_bus.number, res_bus.status, res_bus.last);
    end
  end

  // ---------------------------------------------------------------------------
  // Main stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    int line_no;
    int stop_at;
    rst_ni       = 1'b0;
    ch_bus.valid = 1'b0;
    ch_bus.ch    = CH_NUL;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed string set: an empty string, whitespace alone before the end, a stray symbol
    // while idle, a letter cutting a number, a symbol inside an error token, a bare hex prefix
    // before whitespace and before a non-hex letter, a number ended by a high byte, and an x
    // after leading zeros.
    line_buf.push_back(CH_NUL);
    push_text(" \t");
    line_buf.push_back(CH_NUL);
    push_text("@9a# 0x 0Xz\t5");
    line_buf.push_back(8'hFF);
    push_text("00x1");
    line_buf.push_back(CH_NUL);
    send_line();
    wait_for_results();

    // Random strings. Idle limits change every few lines; twice the receiver holds off for
    // a long stretch while the sender streams with no gaps, and every so often the sender
    // stops until all results are back.
    stop_at = chars_sent + RANDOM_CHARS;
    line_no = 0;
    while (chars_sent < stop_at) begin
      if (line_no % 8 == 0) begin
        src_gap_max = pick_gap_max();
        snk_gap_max = pick_gap_max();
      end
      if (line_no == 3 || line_no == 12) begin
        hold_request = 1'b1;
        src_gap_max  = 0;
      end
      if (line_no % 25 == 24) wait_for_results();
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_line();
      send_line();
      line_no++;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("decimal_hex_token_parser regression: pass");
    end else begin
      $display("decimal_hex_token_parser regression: fail");
    end
    $finish;
  end

endmodule
